/* design/rwc_pkg.sv */
// Package for the rolling weak checksum unit: widths, limits and register map.
// Used by rolling_weak_checksum_unit; no dependencies.
package rwc_pkg;

	// Window store depth and derived widths
	localparam int MAX_WINDOW = 4096;
	localparam int POS_W      = $clog2(MAX_WINDOW);
	localparam int SIZE_W     = POS_W + 1;
	localparam int SUM_W      = 16;
	localparam int BYTE_W     = 8;
	localparam int DIGEST_W   = 2 * SUM_W;

	// Configuration port
	localparam int CFG_AW     = 3;
	localparam int CFG_DW     = 32;
	localparam logic [SIZE_W-1:0] WINDOW_SIZE_RESET = SIZE_W'(512);

	// Register word indexes
	typedef enum logic [0:0] {
		REG_WINDOW_SIZE = 1'b0
	} reg_index_t;

	// Window size in use: zero acts as one, anything above the store depth saturates
	function automatic logic [SIZE_W-1:0] active_size(input logic [SIZE_W-1:0] raw);
		logic [SIZE_W-1:0] n;
		n = raw;
		if (n == '0)
			n = SIZE_W'(1);
		if (n > SIZE_W'(MAX_WINDOW))
			n = SIZE_W'(MAX_WINDOW);
		return n;
	endfunction

endpackage

/* design/rolling_weak_checksum_unit.sv */
// Rolling weak checksum unit (rsync style) over a sliding byte window.
// Depends on rwc_pkg and rwc_ram.
//
// Channel   Dir  Handshake                 Contents
// s_axis    in   tvalid/tready             tdata: data_byte; tuser: restart
// m_axis    out  tvalid/tready             tdata: digest, low_sum, high_sum; tuser: window_full
// apb       in   psel/penable/pwrite       word 0: window_size (13 bits)
//
// One byte per cycle unless m_axis stalls; a result passes stage 1, then the output register.
// The window store is read and rewritten at the same address in the accept cycle;
// the sums are updated in the following stage and land in the output register.
// Reset empties the window and sets window_size to 512; the store needs no clearing.
// A stalled output holds the second stage, which then holds the input side.
// Writing window_size empties the window just as a restart does.
module rolling_weak_checksum_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// byte stream in
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
	input  logic                            s_axis_tuser,  // [0] restart
	// checksum out
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [63:0]                     m_axis_tdata,  // [31:0] digest, [47:32] low_sum,
	                                                       // [63:48] high_sum
	output logic                            m_axis_tuser,  // [0] window_full
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rwc_pkg::CFG_AW-1:0]      paddr,
	input  logic [rwc_pkg::CFG_DW-1:0]      pwdata,
	output logic [rwc_pkg::CFG_DW-1:0]      prdata,
	output logic                            pready
);

	// Configuration register
	logic [rwc_pkg::SIZE_W-1:0] window_size_q;
	logic                       cfg_write;
	logic                       cfg_hit;

	// Window control state
	logic [rwc_pkg::POS_W-1:0]  ring_q;
	logic [rwc_pkg::SIZE_W-1:0] fill_q;
	logic [rwc_pkg::SUM_W-1:0]  sum_a_q;
	logic [rwc_pkg::SUM_W-1:0]  sum_b_q;

	// Accept-side control
	logic                       in_accept;
	logic [rwc_pkg::SIZE_W-1:0] size_eff;
	logic [rwc_pkg::POS_W-1:0]  pos_base;
	logic [rwc_pkg::POS_W-1:0]  pos;
	logic [rwc_pkg::SIZE_W-1:0] pos_next;
	logic [rwc_pkg::SIZE_W-1:0] fill_base;
	logic [rwc_pkg::SIZE_W-1:0] fill_next;
	logic                       fill_phase;

	// Stage 1
	logic                       valid_s1;
	logic [rwc_pkg::BYTE_W-1:0] byte_s1;
	logic                       restart_s1;
	logic                       fill_s1;
	logic                       full_s1;
	logic [rwc_pkg::BYTE_W-1:0] removed;
	logic                       advance_s1;

	// Sum update
	logic [rwc_pkg::SUM_W-1:0]  base_a;
	logic [rwc_pkg::SUM_W-1:0]  base_b;
	logic [rwc_pkg::SUM_W-1:0]  new_a;
	logic [rwc_pkg::SUM_W-1:0]  new_b;
	logic [rwc_pkg::BYTE_W+rwc_pkg::SIZE_W-1:0] removed_weight;

	// Output register
	logic                       out_valid_q;
	logic [rwc_pkg::SUM_W-1:0]  out_a_q;
	logic [rwc_pkg::SUM_W-1:0]  out_b_q;
	logic                       out_full_q;

	// APB decode; pready is tied high
	assign pready    = 1'b1;
	assign cfg_hit   = (paddr[2] == rwc_pkg::REG_WINDOW_SIZE);
	assign cfg_write = psel && penable && pwrite && cfg_hit;
	assign prdata    = cfg_hit ? rwc_pkg::CFG_DW'(window_size_q) : '0;

	// Handshakes
	assign advance_s1    = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance_s1;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	// Ring position and fill count for the request being taken
	always_comb begin
		size_eff  = rwc_pkg::active_size(window_size_q);
		pos_base  = s_axis_tuser ? '0 : ring_q;
		pos       = (rwc_pkg::SIZE_W'(pos_base) >= size_eff) ? '0 : pos_base;
		fill_base = s_axis_tuser ? '0 : fill_q;
		fill_phase = fill_base < size_eff;
		fill_next = fill_phase ? fill_base + rwc_pkg::SIZE_W'(1) : fill_base;
		pos_next  = rwc_pkg::SIZE_W'(pos) + rwc_pkg::SIZE_W'(1);
	end

	// Window store: read the outgoing byte and write the new one in one access
	rwc_ram #(
		.WIDTH (rwc_pkg::BYTE_W),
		.DEPTH (rwc_pkg::MAX_WINDOW)
	) u_window_ram (
		.clk   (clk),
		.en    (in_accept),
		.we    (in_accept),
		.addr  (pos),
		.wdata (s_axis_tdata),
		.rdata (removed)
	);

	// Sum update: fill adds the byte, full window slides it
	always_comb begin
		base_a = restart_s1 ? '0 : sum_a_q;
		base_b = restart_s1 ? '0 : sum_b_q;
		removed_weight = (rwc_pkg::BYTE_W+rwc_pkg::SIZE_W)'(removed) *
			(rwc_pkg::BYTE_W+rwc_pkg::SIZE_W)'(size_eff);
		if (fill_s1) begin
			new_a = base_a + rwc_pkg::SUM_W'(byte_s1);
			new_b = base_b + new_a;
		end else begin
			new_a = base_a + rwc_pkg::SUM_W'(byte_s1) - rwc_pkg::SUM_W'(removed);
			new_b = base_b + new_a - removed_weight[rwc_pkg::SUM_W-1:0];
		end
	end

	// Control state and valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= rwc_pkg::WINDOW_SIZE_RESET;
			ring_q        <= '0;
			fill_q        <= '0;
			sum_a_q       <= '0;
			sum_b_q       <= '0;
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_write) begin
				window_size_q <= pwdata[rwc_pkg::SIZE_W-1:0];
				ring_q        <= '0;
				fill_q        <= '0;
				sum_a_q       <= '0;
				sum_b_q       <= '0;
			end else begin
				if (in_accept) begin
					ring_q <= (pos_next >= size_eff) ? '0 : pos_next[rwc_pkg::POS_W-1:0];
					fill_q <= fill_next;
				end
				if (advance_s1) begin
					sum_a_q <= new_a;
					sum_b_q <= new_b;
				end
			end
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (!out_valid_q || m_axis_tready)
				out_valid_q <= valid_s1;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1    <= s_axis_tdata;
			restart_s1 <= s_axis_tuser;
			fill_s1    <= fill_phase;
			full_s1    <= (fill_next >= size_eff);
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (advance_s1) begin
			out_a_q    <= new_a;
			out_b_q    <= new_b;
			out_full_q <= full_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_b_q, out_a_q, out_b_q, out_a_q};
	assign m_axis_tuser  = out_full_q;

	// Ring position always stays inside the window in use
	a_ring_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		rwc_pkg::SIZE_W'(ring_q) < size_eff)
		else $error("ring position outside window");

	// Fill count never exceeds the window size
	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= size_eff)
		else $error("fill count above window size");

	// Input side stalls only behind a full second stage and a held output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && out_valid_q && !m_axis_tready))
		else $error("input stalled without downstream backpressure");

	// A sliding step only happens on a full window
	a_slide_full: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && !fill_phase) |-> (fill_q == size_eff && !s_axis_tuser))
		else $error("slide on partial window");

	// A taken request reaches stage 1 on the next edge
	a_accept_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> valid_s1)
		else $error("accepted request lost");

endmodule

/* design/rwc_ram.sv */
// Generic single-port RAM with registered, read-first output.
// No dependencies.
module rwc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the old contents when the same address is written
	always_ff @(posedge clk) begin
		if (en) begin
			if (we)
				mem[addr] <= wdata;
			rdata <= mem[addr];
		end
	end

endmodule
